>>> hdl/gpe_pkg.sv
`default_nettype none

package gpe_pkg;

  // Width of every pin-wide field on the ports
  localparam int FIELD_W = 12;

  // Item kinds; the fourth code is unused and does nothing
  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_SAMPLE = 2'd2
  } mode_t;

  // Port register map
  typedef enum logic [3:0] {
    REG_DATA     = 4'd0,
    REG_DIR      = 4'd1,
    REG_SENSE    = 4'd2,
    REG_BOTH     = 4'd3,
    REG_POLARITY = 4'd4,
    REG_ENABLE   = 4'd5,
    REG_RAW      = 4'd6,
    REG_MASKED   = 4'd7,
    REG_CLEAR    = 4'd8
  } reg_idx_t;

  // Command broadcast to every pin lane
  typedef struct packed {
    logic     fire;
    mode_t    mode;
    reg_idx_t idx;
  } lane_cmd_t;

  // What one lane reports for the transfer it just took
  typedef struct packed {
    logic rd;
    logic drive;
    logic oe;
    logic irq;
  } lane_out_t;

endpackage

`default_nettype wire

>>> hdl/gpio_port_edge_interrupt.sv
// GPIO port with masked data access and edge or level interrupts. Each transfer on
// the item channel is a register read, a register write or a pin-sample tick, and
// produces exactly one result on the result channel in the next cycle. One item can
// be taken every cycle: every active pin has its own lane holding its slice of the
// port registers, and a merge stage collects the lane bits into the output register.
// The item channel stalls only while a finished result is held and the sink is
// stalling. pin_drive, pin_output_enable and irq_line in a result show the port
// state after that item; read_data is zero except for reads. PIN_COUNT sets the
// number of active pins (the fields are 12 bits wide; pins past PIN_COUNT read zero).
`default_nettype none

module gpio_port_edge_interrupt #(
  parameter int PIN_COUNT = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   mode,
  input  logic [3:0]                   reg_index,
  input  logic [gpe_pkg::FIELD_W-1:0]  access_mask,
  input  logic [gpe_pkg::FIELD_W-1:0]  write_data,
  input  logic [gpe_pkg::FIELD_W-1:0]  pin_levels,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [gpe_pkg::FIELD_W-1:0]  read_data,
  output logic [gpe_pkg::FIELD_W-1:0]  pin_drive,
  output logic [gpe_pkg::FIELD_W-1:0]  pin_output_enable,
  output logic                         irq_line
);

  localparam int LANE_COUNT = (PIN_COUNT < gpe_pkg::FIELD_W) ? PIN_COUNT : gpe_pkg::FIELD_W;

  gpe_pkg::lane_cmd_t cmd;
  gpe_pkg::lane_out_t lane_res [LANE_COUNT];
  logic               fire;

  // Take a new item unless a held result is stalled
  assign item_stall = result_valid && result_stall;
  assign fire       = item_valid && !item_stall;

  always_comb begin
    cmd.fire = fire;
    cmd.mode = gpe_pkg::mode_t'(mode);
    cmd.idx  = gpe_pkg::reg_idx_t'(reg_index);
  end

  // One lane per active pin
  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    gpe_lane u_lane (
      .clk (clk),
      .rst (rst),
      .cmd (cmd),
      .sel (access_mask[g]),
      .val (write_data[g]),
      .pin (pin_levels[g]),
      .res (lane_res[g])
    );
  end

  gpe_merge #(
    .LANE_COUNT (LANE_COUNT)
  ) u_merge (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .res               (lane_res),
    .result_stall      (result_stall),
    .result_valid      (result_valid),
    .read_data         (read_data),
    .pin_drive         (pin_drive),
    .pin_output_enable (pin_output_enable),
    .irq_line          (irq_line)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("accepted item produced no result");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("item channel stalled with no result held");

  a_idle_irq_steady: assert property (@(posedge clk) disable iff (rst)
    ($past(!fire) && result_valid && $past(result_valid)) |-> $stable(irq_line))
    else $error("result irq changed without a transfer");

endmodule

`default_nettype wire

>>> hdl/gpe_lane.sv
`default_nettype none

module gpe_lane (
  input  logic                clk,
  input  logic                rst,
  input  gpe_pkg::lane_cmd_t  cmd,
  input  logic                sel,
  input  logic                val,
  input  logic                pin,
  output gpe_pkg::lane_out_t  res
);

  logic latch, dir, sense, both, pol, en, raw, prev;
  logic latch_next, dir_next, sense_next, both_next, pol_next, en_next, raw_next, prev_next;
  logic rise, fall, one_edge, edge_hit, level_hit, hit;
  logic rd_bit;

  // Detect the selected event on this pin
  always_comb begin
    rise      = !prev && pin;
    fall      = prev && !pin;
    one_edge  = pol ? rise : fall;
    edge_hit  = both ? (rise || fall) : one_edge;
    level_hit = (pin == pol);
    hit       = sense ? level_hit : edge_hit;
  end

  // Register read for this pin
  always_comb begin
    unique case (cmd.idx)
      gpe_pkg::REG_DATA:     rd_bit = (dir ? latch : prev) && sel;
      gpe_pkg::REG_DIR:      rd_bit = dir;
      gpe_pkg::REG_SENSE:    rd_bit = sense;
      gpe_pkg::REG_BOTH:     rd_bit = both;
      gpe_pkg::REG_POLARITY: rd_bit = pol;
      gpe_pkg::REG_ENABLE:   rd_bit = en;
      gpe_pkg::REG_RAW:      rd_bit = raw;
      gpe_pkg::REG_MASKED:   rd_bit = raw && en;
      default:               rd_bit = 1'b0;
    endcase
  end

  // Next state of this pin's slice of every register
  always_comb begin
    latch_next = latch;
    dir_next   = dir;
    sense_next = sense;
    both_next  = both;
    pol_next   = pol;
    en_next    = en;
    raw_next   = raw;
    prev_next  = prev;
    if (cmd.fire) begin
      unique case (cmd.mode)
        gpe_pkg::MODE_WRITE: begin
          unique case (cmd.idx)
            gpe_pkg::REG_DATA:     if (sel) latch_next = val;
            gpe_pkg::REG_DIR:      dir_next = val;
            gpe_pkg::REG_SENSE:    sense_next = val;
            gpe_pkg::REG_BOTH:     both_next = val;
            gpe_pkg::REG_POLARITY: pol_next = val;
            gpe_pkg::REG_ENABLE:   en_next = val;
            gpe_pkg::REG_CLEAR:    if (val) raw_next = 1'b0;
            default:               ;
          endcase
        end
        gpe_pkg::MODE_SAMPLE: begin
          raw_next  = raw || hit;
          prev_next = pin;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch <= 1'b0;
      dir   <= 1'b0;
      sense <= 1'b0;
      both  <= 1'b0;
      pol   <= 1'b0;
      en    <= 1'b0;
      raw   <= 1'b0;
      prev  <= 1'b0;
    end else begin
      latch <= latch_next;
      dir   <= dir_next;
      sense <= sense_next;
      both  <= both_next;
      pol   <= pol_next;
      en    <= en_next;
      raw   <= raw_next;
      prev  <= prev_next;
    end
  end

  // Report the state after this transfer
  always_comb begin
    res.rd    = (cmd.mode == gpe_pkg::MODE_READ) ? rd_bit : 1'b0;
    res.drive = latch_next;
    res.oe    = dir_next;
    res.irq   = raw_next && en_next;
  end

  a_clear_wins: assert property (@(posedge clk) disable iff (rst)
    (cmd.fire && cmd.mode == gpe_pkg::MODE_WRITE && cmd.idx == gpe_pkg::REG_CLEAR && val)
    |=> !raw)
    else $error("status bit survived a clear");

  a_sample_tracks_pin: assert property (@(posedge clk) disable iff (rst)
    (cmd.fire && cmd.mode == gpe_pkg::MODE_SAMPLE) |=> (prev == $past(pin)))
    else $error("previous sample not updated on tick");

  a_read_no_side_effect: assert property (@(posedge clk) disable iff (rst)
    (cmd.fire && cmd.mode == gpe_pkg::MODE_READ)
    |=> ($stable(raw) && $stable(latch) && $stable(dir)))
    else $error("read changed port state");

endmodule

`default_nettype wire

>>> hdl/gpe_merge.sv
`default_nettype none

module gpe_merge #(
  parameter int LANE_COUNT = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  gpe_pkg::lane_out_t                res [LANE_COUNT],
  input  logic                              result_stall,
  output logic                              result_valid,
  output logic [gpe_pkg::FIELD_W-1:0]       read_data,
  output logic [gpe_pkg::FIELD_W-1:0]       pin_drive,
  output logic [gpe_pkg::FIELD_W-1:0]       pin_output_enable,
  output logic                              irq_line
);

  logic [gpe_pkg::FIELD_W-1:0] rd_all, drive_all, oe_all;
  logic                        irq_any;

  // Gather lane bits; pins past the port stay zero
  always_comb begin
    rd_all    = '0;
    drive_all = '0;
    oe_all    = '0;
    irq_any   = 1'b0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      rd_all[i]    = res[i].rd;
      drive_all[i] = res[i].drive;
      oe_all[i]    = res[i].oe;
      irq_any      = irq_any || res[i].irq;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data         <= rd_all;
      pin_drive         <= drive_all;
      pin_output_enable <= oe_all;
      irq_line          <= irq_any;
    end
  end

endmodule

`default_nettype wire
